[rtl/core/bst_pkg.sv]
// Shared types and constants for the beacon station table.
// Used by bst_ctrl, bst_dp and beacon_station_table_core; no dependencies.
`timescale 1ns / 1ps

package bst_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [16:0] FREQ_BASE   = 17'd2407;
  // (m * FREQ_RECIP) >> RECIP_SHIFT equals m / 5 for every 16-bit m
  localparam logic [15:0] FREQ_RECIP  = 16'd52429;
  localparam int          RECIP_SHIFT = 18;

  localparam logic [1:0] STATUS_ADDED   = 2'd0;
  localparam logic [1:0] STATUS_COUNTED = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_READ    = 2'd3;

  localparam logic CMD_BEACON = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic [47:0] bssid;
    logic [7:0]  signal;
    logic [14:0] channel;
    logic [31:0] beacons;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic rd_issue;
    logic emit_hit;
    logic emit_miss;
    logic emit_read;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/bst_ctrl.sv]
// Controller for the beacon station table: sequences accept, scan and result.
// Depends on bst_pkg; drives bst_dp through dp_cmd_t and reads dp_sts_t.
`timescale 1ns / 1ps

module bst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_cmd_i,
  output logic             in_ready_o,
  input  bst_pkg::dp_sts_t sts_i,
  output bst_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CALC     = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_RD_ISSUE = 3'd5;
  localparam logic [2:0] ST_RD_OUT   = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_cmd_i == bst_pkg::CMD_READ) ? ST_RD_ISSUE : ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.scan_start = 1'b1;
        state_d          = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          state_d = ST_HIT;
        end else if (sts_i.miss) begin
          state_d = ST_MISS;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_HIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_hit = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_miss = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_RD_ISSUE: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_read = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/bst_dp.sv]
// Datapath for the beacon station table: entry memory, scan pointer, fill count,
// channel arithmetic and output register. Depends on bst_pkg.
`timescale 1ns / 1ps

module bst_dp #(
  parameter int TABLE_ENTRIES = bst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bst_pkg::dp_cmd_t cmd_i,
  output bst_pkg::dp_sts_t sts_o,
  input  logic [47:0]      in_bssid_i,
  input  logic [7:0]       in_signal_i,
  input  logic [15:0]      in_freq_i,
  input  logic [5:0]       in_ridx_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       out_status_o,
  output logic [5:0]       out_index_o,
  output logic             out_entry_valid_o,
  output logic [47:0]      out_bssid_o,
  output logic [8:0]       out_signal_dbm_o,
  output logic [14:0]      out_channel_o,
  output logic [31:0]      out_beacons_o,
  output logic [6:0]       out_count_o
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IXW6  = IDX_W + 6;
  localparam int CNW7  = CNT_W + 7;
  localparam int CMPW  = CNT_W + 6;

  bst_pkg::entry_t mem [TABLE_ENTRIES];
  bst_pkg::entry_t rd_data_q;
  logic            rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic            wr_en;
  logic [IDX_W-1:0] wr_addr;
  bst_pkg::entry_t wr_data;

  logic [47:0] bssid_q;
  logic [7:0]  signal_q;
  logic [5:0]  ridx_q;
  logic [15:0] mag_q;
  logic        neg_q;
  logic [31:0] prod_q;

  logic [CNT_W-1:0] filled_q;
  logic [CNT_W-1:0] scan_addr_q;
  logic             rd_pend_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic             out_valid_q;
  logic [1:0]       out_status_q;
  logic [5:0]       out_index_q;
  logic             out_entry_valid_q;
  logic [47:0]      out_bssid_q;
  logic [8:0]       out_signal_q;
  logic [14:0]      out_channel_q;
  logic [31:0]      out_beacons_q;
  logic [6:0]       out_count_q;

  logic [16:0]      diff;
  logic [16:0]      diff_abs;
  logic [14:0]      quot;
  logic [14:0]      channel;
  logic             room;
  logic             scan_more;
  logic             rd_ok;
  logic [IXW6-1:0]  ridx_w;
  logic [IXW6-1:0]  rd_idx_w;
  logic [IXW6-1:0]  filled_idx_w;
  logic [CNW7-1:0]  filled_w;
  logic [CNW7-1:0]  filled_inc_w;
  logic [31:0]      beacons_inc;

  assign diff     = {1'b0, in_freq_i} - bst_pkg::FREQ_BASE;
  assign diff_abs = diff[16] ? (17'd0 - diff) : diff;
  assign quot     = {1'b0, prod_q[bst_pkg::RECIP_SHIFT +: 14]};
  assign channel  = neg_q ? (15'd0 - quot) : quot;

  assign room      = (filled_q != CNT_W'(TABLE_ENTRIES));
  assign scan_more = (scan_addr_q != filled_q);
  assign ridx_w    = IXW6'(ridx_q);
  assign rd_ok     = (CMPW'(ridx_q) < CMPW'(filled_q));
  assign rd_idx_w  = IXW6'(rd_idx_q);
  assign filled_idx_w = IXW6'(filled_q);
  assign filled_w     = CNW7'(filled_q);
  assign filled_inc_w = CNW7'(filled_q) + CNW7'(1);
  assign beacons_inc  = (rd_data_q.beacons == '1) ? rd_data_q.beacons
                                                  : rd_data_q.beacons + 32'd1;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_addr_q[IDX_W-1:0];
    if (cmd_i.rd_issue) begin
      rd_en   = 1'b1;
      rd_addr = ridx_w[IDX_W-1:0];
    end else if (cmd_i.scan_step && scan_more) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_q;
    wr_data = rd_data_q;
    if (cmd_i.emit_hit) begin
      wr_en           = 1'b1;
      wr_data.beacons = beacons_inc;
    end else if (cmd_i.emit_miss && room) begin
      wr_en           = 1'b1;
      wr_addr         = filled_q[IDX_W-1:0];
      wr_data.bssid   = bssid_q;
      wr_data.signal  = signal_q;
      wr_data.channel = channel;
      wr_data.beacons = 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bssid_q  <= in_bssid_i;
      signal_q <= in_signal_i;
      ridx_q   <= in_ridx_i;
      mag_q    <= diff_abs[15:0];
      neg_q    <= diff[16];
    end
    prod_q <= mag_q * bst_pkg::FREQ_RECIP;
    if (cmd_i.scan_step && scan_more) begin
      rd_idx_q <= scan_addr_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q    <= '0;
      scan_addr_q <= '0;
      rd_pend_q   <= 1'b0;
    end else begin
      if (cmd_i.emit_miss && room) begin
        filled_q <= filled_q + CNT_W'(1);
      end
      if (cmd_i.scan_start) begin
        scan_addr_q <= '0;
        rd_pend_q   <= 1'b0;
      end else if (cmd_i.scan_step) begin
        rd_pend_q <= scan_more;
        if (scan_more) begin
          scan_addr_q <= scan_addr_q + CNT_W'(1);
        end
      end
    end
  end

  assign sts_o.hit      = rd_pend_q && (rd_data_q.bssid == bssid_q);
  assign sts_o.miss     = !rd_pend_q && !scan_more;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_hit || cmd_i.emit_miss || cmd_i.emit_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_hit) begin
      out_status_q      <= bst_pkg::STATUS_COUNTED;
      out_index_q       <= rd_idx_w[5:0];
      out_entry_valid_q <= 1'b1;
      out_bssid_q       <= rd_data_q.bssid;
      out_signal_q      <= {1'b1, rd_data_q.signal};
      out_channel_q     <= rd_data_q.channel;
      out_beacons_q     <= beacons_inc;
      out_count_q       <= filled_w[6:0];
    end else if (cmd_i.emit_miss) begin
      if (room) begin
        out_status_q      <= bst_pkg::STATUS_ADDED;
        out_index_q       <= filled_idx_w[5:0];
        out_entry_valid_q <= 1'b1;
        out_bssid_q       <= bssid_q;
        out_signal_q      <= {1'b1, signal_q};
        out_channel_q     <= channel;
        out_beacons_q     <= 32'd1;
        out_count_q       <= filled_inc_w[6:0];
      end else begin
        out_status_q      <= bst_pkg::STATUS_FULL;
        out_index_q       <= '0;
        out_entry_valid_q <= 1'b0;
        out_bssid_q       <= '0;
        out_signal_q      <= '0;
        out_channel_q     <= '0;
        out_beacons_q     <= '0;
        out_count_q       <= filled_w[6:0];
      end
    end else if (cmd_i.emit_read) begin
      out_status_q      <= bst_pkg::STATUS_READ;
      out_index_q       <= ridx_q;
      out_entry_valid_q <= rd_ok;
      out_bssid_q       <= rd_ok ? rd_data_q.bssid : '0;
      out_signal_q      <= rd_ok ? {1'b1, rd_data_q.signal} : '0;
      out_channel_q     <= rd_ok ? rd_data_q.channel : '0;
      out_beacons_q     <= rd_ok ? rd_data_q.beacons : '0;
      out_count_q       <= filled_w[6:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_index_o       = out_index_q;
  assign out_entry_valid_o = out_entry_valid_q;
  assign out_bssid_o       = out_bssid_q;
  assign out_signal_dbm_o  = out_signal_q;
  assign out_channel_o     = out_channel_q;
  assign out_beacons_o     = out_beacons_q;
  assign out_count_o       = out_count_q;

endmodule

[rtl/core/beacon_station_table_core.sv]
// Beacon station table: top level joining bst_ctrl and bst_dp on stream ports.
// Depends on bst_pkg, bst_ctrl and bst_dp.
// A beacon item walks the stored entries, at most TABLE_ENTRIES, until a match, through
// the single memory read port, one entry per cycle. One item is in work at a time.
// Reset clears the fill count and control state; table contents are not cleared.
`timescale 1ns / 1ps

module beacon_station_table_core #(
  parameter int TABLE_ENTRIES = bst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // bssid[47:0], signal_byte[55:48], channel_freq[71:56], read_index[77:72]
  input  logic [79:0]  s_axis_tdata,
  // command[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_index[5:0], entry_valid[6], entry_bssid[54:7], signal_dbm[63:55],
  // channel[78:64], beacon_count[110:79], entry_count[117:111]
  output logic [119:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  bst_pkg::dp_cmd_t cmd;
  bst_pkg::dp_sts_t sts;

  logic [5:0]  out_index;
  logic        out_entry_valid;
  logic [47:0] out_bssid;
  logic [8:0]  out_signal_dbm;
  logic [14:0] out_channel;
  logic [31:0] out_beacons;
  logic [6:0]  out_count;

  bst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bst_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_bssid_i        (s_axis_tdata[47:0]),
    .in_signal_i       (s_axis_tdata[55:48]),
    .in_freq_i         (s_axis_tdata[71:56]),
    .in_ridx_i         (s_axis_tdata[77:72]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_status_o      (m_axis_tuser),
    .out_index_o       (out_index),
    .out_entry_valid_o (out_entry_valid),
    .out_bssid_o       (out_bssid),
    .out_signal_dbm_o  (out_signal_dbm),
    .out_channel_o     (out_channel),
    .out_beacons_o     (out_beacons),
    .out_count_o       (out_count)
  );

  assign m_axis_tdata = {2'b00, out_count, out_beacons, out_channel, out_signal_dbm,
                         out_bssid, out_entry_valid, out_index};

endmodule

[sim/tb_beacon_station_table_core.sv]
// Self-checking testbench for beacon_station_table_core: directed and random beacon
// and read items against an in-bench table predictor, with random idling on both sides.
// Depends on bst_pkg and beacon_station_table_core.
`timescale 1ns / 1ps

module tb_beacon_station_table_core;

  localparam int AP_SLOTS       = bst_pkg::TABLE_ENTRIES_DEF;
  localparam int FREQ_STEP      = 5;
  localparam int RANDOM_ITEMS   = 1080;
  localparam int CALM_ITEMS     = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = AP_SLOTS + 16;

  typedef struct packed {
    logic        cmd;
    logic [47:0] bssid;
    logic [7:0]  sig;
    logic [15:0] freq;
    logic [5:0]  ridx;
    logic        hold;
  } beacon_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  index;
    logic        valid;
    logic [47:0] bssid;
    logic [8:0]  dbm;
    logic [14:0] channel;
    logic [31:0] count;
    logic [6:0]  fill;
  } table_reply_t;

  logic         clk_i     = 1'b0;
  logic         rst_ni    = 1'b0;
  logic         in_valid  = 1'b0;
  logic         in_ready;
  logic [79:0]  in_data   = '0;
  logic [0:0]   in_cmd    = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [119:0] out_data;
  logic [1:0]   out_user;

  beacon_item_t pending[$];
  table_reply_t reply_q[$];
  beacon_item_t cur_item;
  int           total_items  = 0;
  int           sent_count   = 0;
  int           results_seen = 0;
  int           errors       = 0;
  int           send_gap     = 0;
  int           stall_left   = 0;
  int           quiet_cycles = 0;

  logic [47:0]  ap_bssid   [AP_SLOTS];
  logic [7:0]   ap_signal  [AP_SLOTS];
  logic [14:0]  ap_channel [AP_SLOTS];
  logic [31:0]  ap_count   [AP_SLOTS];
  int           ap_filled = 0;

  beacon_station_table_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(in_valid),
    .s_axis_tready(in_ready),
    .s_axis_tdata (in_data),
    .s_axis_tuser (in_cmd),
    .m_axis_tvalid(out_valid),
    .m_axis_tready(out_ready),
    .m_axis_tdata (out_data),
    .m_axis_tuser (out_user)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic beacon_item_t item_of(logic cmd, logic [47:0] bssid, logic [7:0] sig,
                                           logic [15:0] freq, logic [5:0] ridx);
    beacon_item_t it;
    it.cmd   = cmd;
    it.bssid = bssid;
    it.sig   = sig;
    it.freq  = freq;
    it.ridx  = ridx;
    it.hold  = 1'b0;
    return it;
  endfunction

  function automatic table_reply_t predict_reply(beacon_item_t it);
    table_reply_t r;
    int           slot;
    int           ch;
    r    = '{default: '0};
    slot = -1;
    if (it.cmd == bst_pkg::CMD_READ) begin
      r.status = bst_pkg::STATUS_READ;
      r.index  = it.ridx;
      if (it.ridx < ap_filled) slot = it.ridx;
    end else begin
      for (int i = 0; i < ap_filled; i++) begin
        if (slot < 0 && ap_bssid[i] == it.bssid) slot = i;
      end
      if (slot >= 0) begin
        if (ap_count[slot] != '1) ap_count[slot] = ap_count[slot] + 1;
        r.status = bst_pkg::STATUS_COUNTED;
      end else if (ap_filled < AP_SLOTS) begin
        slot             = ap_filled;
        ch               = (int'(it.freq) - int'(bst_pkg::FREQ_BASE)) / FREQ_STEP;
        ap_bssid[slot]   = it.bssid;
        ap_signal[slot]  = it.sig;
        ap_channel[slot] = ch[14:0];
        ap_count[slot]   = 32'd1;
        ap_filled++;
        r.status = bst_pkg::STATUS_ADDED;
      end else begin
        r.status = bst_pkg::STATUS_FULL;
      end
      if (slot >= 0) r.index = slot[5:0];
    end
    if (slot >= 0) begin
      r.valid   = 1'b1;
      r.bssid   = ap_bssid[slot];
      r.dbm     = {1'b1, ap_signal[slot]};
      r.channel = ap_channel[slot];
      r.count   = ap_count[slot];
    end
    r.fill = ap_filled[6:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // stimulus: directed items, then random beacons and reads
  initial begin
    beacon_item_t it;
    logic [47:0]  known[$];
    int           roll;
    pending.push_back(item_of(bst_pkg::CMD_READ,   48'h0,            8'h00, 16'd0,    6'd0));
    pending.push_back(item_of(bst_pkg::CMD_READ,   48'h0,            8'h00, 16'd0,    6'd63));
    pending.push_back(item_of(bst_pkg::CMD_BEACON, 48'h0,            8'h00, 16'd0,    6'd0));
    pending.push_back(item_of(bst_pkg::CMD_BEACON, 48'hFFFFFFFFFFFF, 8'hFF, 16'hFFFF, 6'd63));
    pending.push_back(item_of(bst_pkg::CMD_BEACON, 48'h0,            8'h7F, 16'd2412, 6'd21));
    pending.push_back(item_of(bst_pkg::CMD_BEACON, 48'h800000000000, 8'hA5, 16'd2407, 6'd42));
    pending.push_back(item_of(bst_pkg::CMD_BEACON, 48'h000000000001, 8'h01, 16'd2406, 6'd0));
    pending.push_back(item_of(bst_pkg::CMD_BEACON, 48'h7FFFFFFFFFFF, 8'h80, 16'd2412, 6'd0));
    pending.push_back(item_of(bst_pkg::CMD_BEACON, 48'hFFFFFFFFFFFE, 8'hC4, 16'd5180, 6'd0));
    pending.push_back(item_of(bst_pkg::CMD_BEACON, 48'h0123456789AB, 8'hD0, 16'd2411, 6'd0));
    pending.push_back(item_of(bst_pkg::CMD_BEACON, 48'hFFFFFFFFFFFF, 8'h00, 16'd0,    6'd0));
    pending.push_back(item_of(bst_pkg::CMD_READ,   48'hFFFFFFFFFFFF, 8'hFF, 16'hFFFF, 6'd0));
    pending.push_back(item_of(bst_pkg::CMD_READ,   48'h0,            8'h00, 16'd0,    6'd1));
    pending.push_back(item_of(bst_pkg::CMD_READ,   48'h0,            8'h00, 16'd0,    6'd3));
    pending.push_back(item_of(bst_pkg::CMD_READ,   48'h0,            8'h00, 16'd0,    6'd6));
    pending.push_back(item_of(bst_pkg::CMD_READ,   48'h0,            8'h00, 16'd0,    6'd7));
    pending.push_back(item_of(bst_pkg::CMD_READ,   48'h0,            8'h00, 16'd0,    6'd63));
    pending.push_back(item_of(bst_pkg::CMD_BEACON, 48'h000000000001, 8'h10, 16'd5825, 6'd0));
    pending.push_back(item_of(bst_pkg::CMD_READ,   48'h0,            8'h00, 16'd0,    6'd4));
    known = '{48'h0, 48'hFFFFFFFFFFFF, 48'h800000000000, 48'h000000000001,
              48'h7FFFFFFFFFFF, 48'hFFFFFFFFFFFE, 48'h0123456789AB};
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll     = $urandom_range(0, 99);
      it.cmd   = bst_pkg::CMD_BEACON;
      it.bssid = {16'($urandom), 32'($urandom)};
      it.sig   = 8'($urandom);
      it.freq  = $urandom_range(0, 1) ? 16'($urandom) :
                 $urandom_range(0, 1) ? 16'(2412 + 5 * $urandom_range(0, 12)) :
                                        16'(5180 + 20 * $urandom_range(0, 32));
      it.ridx  = 6'($urandom);
      it.hold  = (n % 256 == 0);
      if (roll < 30) begin
        it.cmd = bst_pkg::CMD_READ;
      end else if (roll < 80) begin
        it.bssid = known[$urandom_range(0, known.size() - 1)];
      end else begin
        if (roll < 88) begin
          it.bssid = known[$urandom_range(0, known.size() - 1)];
          it.bssid[$urandom_range(0, 47)] ^= 1'b1;
        end
        known.push_back(it.bssid);
      end
      pending.push_back(it);
    end
    total_items = pending.size();

    wait (results_seen == total_items);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // driver
  always @(posedge clk_i) begin
    beacon_item_t nxt;
    logic         fire;
    if (rst_ni) begin
      fire = in_valid && in_ready;
      if (fire) begin
        reply_q.push_back(predict_reply(cur_item));
        sent_count++;
      end
      if (!in_valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0 && (!pending[0].hold || results_seen == sent_count)) begin
          nxt      = pending.pop_front();
          cur_item = nxt;
          in_valid <= 1'b1;
          in_data  <= {2'b00, nxt.ridx, nxt.freq, nxt.sig, nxt.bssid};
          in_cmd   <= nxt.cmd;
          if (pending.size() > CALM_ITEMS && (sent_count / 150) % 3 != 2 &&
              $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    table_reply_t got;
    table_reply_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        got.status  = out_user;
        got.index   = out_data[5:0];
        got.valid   = out_data[6];
        got.bssid   = out_data[54:7];
        got.dbm     = out_data[63:55];
        got.channel = out_data[78:64];
        got.count   = out_data[110:79];
        got.fill    = out_data[117:111];
        if (reply_q.size() == 0) begin
          errors++;
          $display("%0t: result expected none, actual status %0h index %0h", $time,
                   got.status, got.index);
        end else begin
          want = reply_q.pop_front();
          check_field("status",       want.status,  got.status);
          check_field("entry_index",  want.index,   got.index);
          check_field("entry_valid",  want.valid,   got.valid);
          check_field("entry_bssid",  want.bssid,   got.bssid);
          check_field("signal_dbm",   want.dbm,     got.dbm);
          check_field("channel",      want.channel, got.channel);
          check_field("beacon_count", want.count,   got.count);
          check_field("entry_count",  want.fill,    got.fill);
        end
        results_seen <= results_seen + 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (results_seen < total_items - CALM_ITEMS && (results_seen / 170) % 3 != 1 &&
                   $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
